// File: design/gm3_pkg.sv
// ----------------------------------------------------------------------------
// gm3_pkg
// Shared types and constants for the 3x3 gradient magnitude block.
// ----------------------------------------------------------------------------
package gm3_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int PixBits   = 8;
   localparam int AddrBits  = $clog2(MaxWidth);
   localparam int PosBits   = 10;
   localparam int DimBits   = 11;
   localparam int CoefBits  = 36;

   localparam logic [1:0] RegKx     = 2'd0;
   localparam logic [1:0] RegKy     = 2'd1;
   localparam logic [1:0] RegWidth  = 2'd2;
   localparam logic [1:0] RegHeight = 2'd3;

   typedef struct packed {
      logic [9*PixBits-1:0] win;
      logic [PosBits-1:0]   row;
      logic [PosBits-1:0]   col;
      logic                 last;
   } job_type;

endpackage

// File: design/gm3_fifo.sv
// ----------------------------------------------------------------------------
// gm3_fifo
// Two-entry queue of window jobs between the front and back parts.
// ----------------------------------------------------------------------------
module gm3_fifo
   import gm3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output job_type pop_data
);
   job_type     mem_ff [2];
   logic        wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

// File: design/gm3_front.sv
// ----------------------------------------------------------------------------
// gm3_front
// Tracks raster position, keeps the two line stores and the 3x3 window,
// and queues a job for every interior centre pixel.
// ----------------------------------------------------------------------------
module gm3_front
   import gm3_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [PixBits-1:0] in_pixel,
   input  logic               in_start,
   input  logic [DimBits-1:0] width,
   input  logic [DimBits-1:0] height,
   input  logic               q_full,
   output logic               q_push,
   output job_type            q_data
);
   localparam logic StIdle = 1'b0;
   localparam logic StRead = 1'b1;

   logic [PixBits-1:0]   up_mem [MaxWidth];
   logic [PixBits-1:0]   lo_mem [MaxWidth];
   logic                 state_ff, state_in;
   logic [PosBits-1:0]   row_ff, row_in, col_ff, col_in;
   logic [PixBits-1:0]   pix_ff, up_rd_ff, lo_rd_ff;
   logic [9*PixBits-1:0] win_ff, win_in;
   logic [AddrBits-1:0]  rd_addr;
   logic [DimBits-1:0]   row_x, col_x, row_n, col_n;
   logic                 accept;

   assign in_ready = (state_ff == StIdle) && !q_full;
   assign accept   = in_valid && in_ready;
   assign rd_addr  = in_start ? '0 : col_ff[AddrBits-1:0];
   assign row_x    = {1'b0, row_ff};
   assign col_x    = {1'b0, col_ff};
   assign row_n    = row_x + 11'd1;
   assign col_n    = col_x + 11'd1;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      win_in   = win_ff;
      q_push   = 1'b0;
      q_data.win  = '0;
      q_data.row  = row_ff - 10'd1;
      q_data.col  = col_ff - 10'd1;
      q_data.last = (row_x == height - 11'd1) && (col_x == width - 11'd1);
      case (state_ff)
         StIdle: begin
            if (accept) begin
               state_in = StRead;
               if (in_start) begin
                  row_in = '0;
                  col_in = '0;
               end
            end
         end
         StRead: begin
            state_in = StIdle;
            for (int r = 0; r < 3; r++) begin
               win_in[(3*r)*PixBits +: PixBits]   = win_ff[(3*r+1)*PixBits +: PixBits];
               win_in[(3*r+1)*PixBits +: PixBits] = win_ff[(3*r+2)*PixBits +: PixBits];
            end
            win_in[2*PixBits +: PixBits] = up_rd_ff;
            win_in[5*PixBits +: PixBits] = lo_rd_ff;
            win_in[8*PixBits +: PixBits] = pix_ff;
            q_data.win = win_in;
            q_push = (row_x >= 11'd2) && (col_x >= 11'd2) && (row_x < height)
                     && (col_x < width);
            if (col_n >= width) begin
               col_in = '0;
               row_in = (row_n >= height) ? '0 : row_n[PosBits-1:0];
            end else begin
               col_in = col_n[PosBits-1:0];
               if (row_x >= height) begin
                  row_in = '0;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         row_ff   <= '0;
         col_ff   <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= in_pixel;
         up_rd_ff <= up_mem[rd_addr];
         lo_rd_ff <= lo_mem[rd_addr];
      end
      if (state_ff == StRead) begin
         up_mem[col_ff[AddrBits-1:0]] <= lo_rd_ff;
         lo_mem[col_ff[AddrBits-1:0]] <= pix_ff;
      end
   end
endmodule

// File: design/gm3_back.sv
// ----------------------------------------------------------------------------
// gm3_back
// Applies both kernels to a queued window, squares and sums the gradients,
// takes the integer square root two bits a cycle and holds the result beat.
// ----------------------------------------------------------------------------
module gm3_back
   import gm3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CoefBits-1:0] kx,
   input  logic [CoefBits-1:0] ky,
   input  logic                q_avail,
   output logic                q_pop,
   input  job_type             q_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [15:0]         out_gx,
   output logic [15:0]         out_gy,
   output logic [14:0]         out_mag,
   output logic [PosBits-1:0]  out_row,
   output logic [PosBits-1:0]  out_col,
   output logic                out_last
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StSq   = 3'd1;
   localparam logic [2:0] StSum  = 3'd2;
   localparam logic [2:0] StRoot = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic signed [15:0]  gx_ff, gy_ff, gx_in, gy_in;
   logic [29:0]         sqx_ff, sqy_ff;
   logic [31:0]         v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [3:0]          step_ff, step_in;
   logic [PosBits-1:0]  row_ff, col_ff;
   logic                last_ff;
   logic [31:0]         trial;

   assign q_pop     = (state_ff == StIdle) && q_avail;
   assign out_valid = state_ff == StOut;
   assign out_gx    = gx_ff;
   assign out_gy    = gy_ff;
   assign out_mag   = res_ff[14:0];
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_last  = last_ff;
   assign trial     = res_ff + bit_ff;

   always_comb begin
      gx_in = '0;
      gy_in = '0;
      for (int n = 0; n < 9; n++) begin
         gx_in = gx_in + 16'(signed'(kx[4*n +: 4])
                 * signed'({1'b0, q_data.win[n*PixBits +: PixBits]}));
         gy_in = gy_in + 16'(signed'(ky[4*n +: 4])
                 * signed'({1'b0, q_data.win[n*PixBits +: PixBits]}));
      end
   end

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      step_in  = step_ff;
      case (state_ff)
         StIdle: if (q_avail) state_in = StSq;
         StSq:   state_in = StSum;
         StSum: begin
            state_in = StRoot;
            v_in     = {2'b00, sqx_ff} + {2'b00, sqy_ff};
            res_in   = '0;
            bit_in   = 32'h4000_0000;
            step_in  = '0;
         end
         StRoot: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) state_in = StOut;
         end
         StOut: if (out_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      step_ff <= step_in;
      if (q_pop) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         row_ff  <= q_data.row;
         col_ff  <= q_data.col;
         last_ff <= q_data.last;
      end
      if (state_ff == StSq) begin
         sqx_ff <= 30'(gx_ff * gx_ff);
         sqy_ff <= 30'(gy_ff * gy_ff);
      end
   end
endmodule

// File: design/gradient_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_3x3
// 3x3 kernel gradient and magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order; tuser set on a beat puts
// that pixel at row 0, column 0. Each interior centre pixel yields one rsp_
// beat carrying gx, gy, floor(sqrt(gx^2+gy^2)) and the centre position;
// tlast marks the final interior result of the image. Border pixels yield
// nothing. In the front a pixel goes through a line store read, then a window
// update, before the next is taken; input is accepted only while the queue
// has room. In the back a result goes through squaring, summing and the
// square root unit that settles two bits a cycle, and the next window waits
// until the beat is taken. A stalled rsp_ receiver holds the result beat; up
// to two windows wait in the queue and the front keeps accepting until it is
// full. Reset clears position, window and control and loads width 640 and
// height 480; kernels reset to zero. The user must write registers on the
// csr_ port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module gradient_magnitude_3x3
   import gm3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // pixel_value
   input  logic                req_tuser,   // frame_start
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,   // grad_x, grad_y, magnitude, centre_row, centre_col
   output logic                rsp_tlast,   // frame_last
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CoefBits-1:0] csr_wdata
);
   logic [CoefBits-1:0] kx_ff, ky_ff;
   logic [DimBits-1:0]  w_ff, h_ff, w_eff, h_eff;
   logic                q_full, q_push, q_avail, q_pop;
   job_type             q_in, q_out;
   logic [15:0]         gx, gy;
   logic [14:0]         mag;
   logic [PosBits-1:0]  row, col;

   always_ff @(posedge clock) begin
      if (reset) begin
         kx_ff <= '0;
         ky_ff <= '0;
         w_ff  <= 11'd640;
         h_ff  <= 11'd480;
      end else if (csr_we) begin
         case (csr_index)
            RegKx:     kx_ff <= csr_wdata;
            RegKy:     ky_ff <= csr_wdata;
            RegWidth:  w_ff  <= csr_wdata[DimBits-1:0];
            RegHeight: h_ff  <= csr_wdata[DimBits-1:0];
            default:   ;
         endcase
      end
   end

   assign w_eff = (w_ff < 11'd3) ? 11'd3 : ((w_ff > 11'(MaxWidth)) ? 11'(MaxWidth) : w_ff);
   assign h_eff = (h_ff < 11'd3) ? 11'd3 : ((h_ff > 11'(MaxHeight)) ? 11'(MaxHeight) : h_ff);

   gm3_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_pixel(req_tdata), .in_start(req_tuser),
      .width(w_eff), .height(h_eff),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   gm3_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in), .full(q_full),
      .not_empty(q_avail), .pop(q_pop), .pop_data(q_out)
   );

   gm3_back u_back (
      .clock(clock), .reset(reset),
      .kx(kx_ff), .ky(ky_ff),
      .q_avail(q_avail), .q_pop(q_pop), .q_data(q_out),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_gx(gx), .out_gy(gy), .out_mag(mag),
      .out_row(row), .out_col(col), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'b0, col, row, mag, gy, gx};
endmodule

// File: design/gm3_checker.sv
// ----------------------------------------------------------------------------
// gm3_checker
// Port-level checks on the gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module gm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tlast
);
   // A result beat is held until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat dropped or changed while stalled");

   // The front never takes pixels on consecutive cycles.
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel accepted on back-to-back cycles");

   // After a taken beat the back part goes back to idle, so results never come back to back.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("result beats too close together");

   // Zero gradients always give a zero magnitude.
   a_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:0] == 16'd0 && rsp_tdata[31:16] == 16'd0
      |-> rsp_tdata[46:32] == 15'd0)
      else $error("nonzero magnitude for zero gradients");
endmodule

bind gradient_magnitude_3x3 gm3_checker u_gm3_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
